@@ rtl/core/erl_pkg.sv @@
// Shared types and constants for the event rate limiter.
package erl_pkg;

   localparam int CUE_W      = 4;
   localparam int TICK_W     = 64;
   localparam int CNT_W      = 4;
   localparam int CD_W       = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int WARN_IDX_W = 3;

   // Cue codes at the edges of the swing group and the warning group.
   localparam logic [CUE_W-1:0] SWING_LAST_CUE = 4'd2;
   localparam logic [CUE_W-1:0] WARN_FIRST_CUE = 4'd8;

   localparam logic [CD_W-1:0] COOLDOWN_RESET = 8'd12;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN = 4'd1;

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_INVALID  = 2'd1,
      VERDICT_BUDGET   = 2'd2,
      VERDICT_COOLDOWN = 2'd3
   } verdict_type;

   typedef struct packed {
      logic                  cat_valid;
      logic [CUE_W-1:0]      cat;
      logic                  warn_valid;
      logic [WARN_IDX_W-1:0] warn;
   } cue_info_type;

endpackage

@@ rtl/core/erl_decode.sv @@
// Cue decoder: maps a cue code to its category and warning slot.
module erl_decode #(
   parameter int NUM_CATEGORIES = 9,
   parameter int NUM_WARNINGS   = 3
) (
   input  logic [erl_pkg::CUE_W-1:0] cue,
   output erl_pkg::cue_info_type     info
);
   import erl_pkg::*;

   logic [CUE_W-1:0] cat_full;
   logic [CUE_W-1:0] warn_off;

   always_comb begin
      cat_full = (cue <= SWING_LAST_CUE) ? '0 : cue - SWING_LAST_CUE;
      warn_off = cue - WARN_FIRST_CUE;
      info.cat_valid  = {1'b0, cat_full} < (CUE_W+1)'(NUM_CATEGORIES);
      info.cat        = cat_full;
      info.warn_valid = (cue >= WARN_FIRST_CUE) &&
                        ({1'b0, warn_off} < (CUE_W+1)'(NUM_WARNINGS));
      info.warn       = warn_off[WARN_IDX_W-1:0];
   end

endmodule

@@ rtl/core/erl_budget.sv @@
// Per-tick category counters with the budget compare.
module erl_budget #(
   parameter int NUM_CATEGORIES = 9
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [erl_pkg::TICK_W-1:0]               tick,
   input  logic [erl_pkg::CUE_W-1:0]                cat,
   input  logic [erl_pkg::CNT_W*NUM_CATEGORIES-1:0] limits,
   input  logic                                     commit,
   input  logic                                     grant,
   output logic                                     count_ok
);
   import erl_pkg::*;

   localparam int CW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

   logic [CNT_W-1:0]  counts_ff [NUM_CATEGORIES];
   logic [TICK_W-1:0] counted_tick_ff;
   logic              counted_valid_ff;
   logic              new_tick;
   logic [CNT_W-1:0]  count_cur;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  limit_sel;
   logic [CW-1:0]     cat_idx;

   always_comb begin
      cat_idx   = cat[CW-1:0];
      new_tick  = !counted_valid_ff || (tick != counted_tick_ff);
      count_cur = new_tick ? '0 : counts_ff[cat_idx];
      limit_sel = limits[{cat_idx, 2'b00} +: CNT_W];
      count_ok  = count_cur < limit_sel;
      count_in  = count_cur + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counted_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CATEGORIES; i++) counts_ff[i] <= '0;
      end else if (commit) begin
         if (new_tick) begin
            counted_valid_ff <= 1'b1;
            for (int i = 0; i < NUM_CATEGORIES; i++) counts_ff[i] <= '0;
         end
         if (grant) counts_ff[cat_idx] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && new_tick) counted_tick_ff <= tick;
   end

endmodule

@@ rtl/core/erl_cooldown.sv @@
// Warning cooldown tracker: last granted tick of each warning cue.
module erl_cooldown #(
   parameter int NUM_WARNINGS = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [erl_pkg::TICK_W-1:0]     tick,
   input  logic [erl_pkg::WARN_IDX_W-1:0] warn,
   input  logic [erl_pkg::CD_W-1:0]       cooldown,
   input  logic                           record,
   output logic                           blocked
);
   import erl_pkg::*;

   localparam int WW = (NUM_WARNINGS > 1) ? $clog2(NUM_WARNINGS) : 1;

   logic [TICK_W-1:0]     last_tick_ff [NUM_WARNINGS];
   logic [NUM_WARNINGS-1:0] seen_ff;
   logic [WW-1:0]         w_idx;
   logic [TICK_W-1:0]     last_sel;
   logic [TICK_W-1:0]     tick_gap;

   always_comb begin
      w_idx    = warn[WW-1:0];
      last_sel = last_tick_ff[w_idx];
      tick_gap = tick - last_sel;
      // A tick that moved backwards never blocks.
      blocked  = seen_ff[w_idx] && (tick >= last_sel) &&
                 (tick_gap[TICK_W-1:CD_W] == '0) && (tick_gap[CD_W-1:0] < cooldown);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (record) begin
         seen_ff[w_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (record) last_tick_ff[w_idx] <= tick;
   end

endmodule

@@ rtl/core/event_rate_limiter.sv @@
// Event rate limiter top level: configuration, decision and result register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cue, req_tick
//   rsp      out        rsp_valid/rsp_stall  rsp_granted, rsp_verdict
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Every request transaction produces exactly one response, presented in the next
// cycle; a new request can be taken every cycle, limited only by the single
// result register. The decision is one pass of logic from the request ports
// through the counter compare and the 64-bit cooldown subtract into that register.
// Synchronous reset clears the counters, the counted-tick flag, the warning flags
// and the result valid; the limits and cooldown return to their default values.
// While a response is held by rsp_stall, req_stall is raised so the held result
// is never overwritten; the csr port is always ready.
module event_rate_limiter #(
   parameter int          NUM_CATEGORIES = 9,
   parameter int          NUM_WARNINGS   = 3,
   parameter logic [63:0] LIMITS_RESET   = 64'h0000_0001_1121_1131
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [erl_pkg::CUE_W-1:0]          req_cue,
   input  logic [erl_pkg::TICK_W-1:0]         req_tick,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_granted,
   output logic [1:0]                         rsp_verdict,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [erl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [erl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import erl_pkg::*;

   localparam int LW = CNT_W * NUM_CATEGORIES;

   logic [LW-1:0]   limits_ff;
   logic [CD_W-1:0] cooldown_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            granted_ff;
   verdict_type     verdict_ff;
   verdict_type     verdict_in;

   cue_info_type    info;
   logic            accept;
   logic            count_ok;
   logic            blocked;
   logic            grant;

   // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff   <= LIMITS_RESET[LW-1:0];
         cooldown_ff <= COOLDOWN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LIMITS)   limits_ff   <= csr_wdata[LW-1:0];
         if (csr_index == CSR_COOLDOWN) cooldown_ff <= csr_wdata[CD_W-1:0];
      end
   end

   // The request side stalls only while a finished result is held downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   erl_decode #(
      .NUM_CATEGORIES(NUM_CATEGORIES),
      .NUM_WARNINGS  (NUM_WARNINGS)
   ) u_decode (
      .cue (req_cue),
      .info(info)
   );

   // Invalid cues leave the counters and cooldown state untouched, including the tick clear.
   erl_budget #(
      .NUM_CATEGORIES(NUM_CATEGORIES)
   ) u_budget (
      .clock   (clock),
      .reset   (reset),
      .tick    (req_tick),
      .cat     (info.cat),
      .limits  (limits_ff),
      .commit  (accept && info.cat_valid),
      .grant   (grant),
      .count_ok(count_ok)
   );

   erl_cooldown #(
      .NUM_WARNINGS(NUM_WARNINGS)
   ) u_cooldown (
      .clock   (clock),
      .reset   (reset),
      .tick    (req_tick),
      .warn    (info.warn),
      .cooldown(cooldown_ff),
      .record  (accept && grant && info.warn_valid),
      .blocked (blocked)
   );

   // The checks are ordered: invalid cue first, then the budget, then cooldown.
   always_comb begin
      priority if (!info.cat_valid)               verdict_in = VERDICT_INVALID;
      else if (!count_ok)                         verdict_in = VERDICT_BUDGET;
      else if (info.warn_valid && blocked)        verdict_in = VERDICT_COOLDOWN;
      else                                        verdict_in = VERDICT_OK;
      grant        = (verdict_in == VERDICT_OK);
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         granted_ff <= grant;
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = granted_ff;
   assign rsp_verdict = verdict_ff;

   // A granted response always carries the allowed verdict.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (granted_ff == (verdict_ff == VERDICT_OK)))
      else $error("grant flag disagrees with verdict");

   // An invalid cue yields an invalid-cue response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !info.cat_valid) |=> (rsp_valid_ff && verdict_ff == VERDICT_INVALID))
      else $error("invalid cue not reported");

   // Requests are held off only while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with no pending response");

   // A response that was held and not taken is still presented.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("held response lost");

endmodule
